/* sv/odpr_pkg.sv */
// shared types, constants and codes of the dirty page refresher
package odpr_pkg;

    localparam int MAX_WIDTH = 128;
    localparam int MAX_PAGES = 8;
    localparam int FB_BYTES  = 1024;
    localparam int FB_AW     = $clog2(FB_BYTES);

    localparam logic [7:0] CTRL_CMD   = 8'h80;
    localparam logic [7:0] PAGE_CMD   = 8'hB0;
    localparam logic [7:0] COL_LO_CMD = 8'h00;
    localparam logic [7:0] COL_HI_CMD = 8'h10;
    localparam logic [7:0] DATA_CMD   = 8'h40;

    localparam logic [9:0] FB_LAST_ADDR = 10'(FB_BYTES - 1);

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_PAGES  = 2'd1,
        REG_OFFSET = 2'd2,
        REG_NONE   = 2'd3
    } reg_idx_t;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_TICK  = 1'b1
    } action_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH,
        ST_READ,
        ST_EMIT,
        ST_FINAL
    } state_t;

    typedef logic [7:0][7:0] oct_bytes_t;

    typedef struct packed {
        logic             we;
        logic [FB_AW-1:0] waddr;
        logic [7:0]       wdata;
        logic             re;
        logic [FB_AW-1:0] raddr;
    } fb_req_t;

endpackage

/* sv/odpr_fb_ram.sv */
// frame store memory, one write and one registered read port
module odpr_fb_ram
    import odpr_pkg::*;
(
    input  logic       aclk,
    input  fb_req_t    req,
    output logic [7:0] rdata
);

    logic [7:0] mem [FB_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/odpr_col_gather.sv */
// collects eight row bytes of a page and presents them as eight column bytes
module odpr_col_gather
    import odpr_pkg::*;
(
    input  logic       aclk,
    input  logic       shift_en,
    input  logic [7:0] din,
    output oct_bytes_t cols
);

    oct_bytes_t rows_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            rows_reg <= {din, rows_reg[7:1]};
        end
    end

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            for (int i = 0; i < 8; i++) begin
                cols[b][i] = rows_reg[i][b];
            end
        end
    end

endmodule

/* sv/oled_dirty_page_refresher_core.sv */
// top level of the dirty page refresher: sequencer, registers and output word
//
// After reset the frame store is cleared one byte a cycle while s_ready stays
// low; configuration writes are taken meanwhile. A write word, like a tick that
// finds no dirty page, is handled in the idle state. A tick that refreshes a
// page first searches the pages in turn for a dirty one, then for each group of
// eight columns makes eight reads of the single frame store read port, waits
// for the read latency and emits one word, then emits the final word; any stall
// on the result side stretches this. The block takes no new word until the
// last result of a page is in the output register.
module oled_dirty_page_refresher_core
    import odpr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [9:0]  s_fb_address,
    input  logic [7:0]  s_fb_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_page_number,
    output logic [63:0] m_out_bytes,
    output logic [3:0]  m_byte_count,
    output logic        m_last
);

    logic [7:0] width_cols_reg;
    logic [3:0] page_count_reg;
    logic [7:0] col_offset_reg;

    state_t state_reg, state_next;
    logic [7:0]       dirty_reg, dirty_next;
    logic [2:0]       next_page_reg, next_page_next;
    logic [2:0]       p_reg, p_next;
    logic [FB_AW-1:0] row_addr_reg, row_addr_next;
    logic [FB_AW-1:0] grp_addr_reg, grp_addr_next;
    logic [3:0]       row_cnt_reg, row_cnt_next;
    logic [3:0]       grp_cnt_reg, grp_cnt_next;
    logic [55:0]      carry_reg, carry_next;
    logic [FB_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic             rd_pend_reg, rd_pend_next;

    logic        m_valid_reg, m_valid_next;
    logic [2:0]  m_page_reg, m_page_next;
    logic [63:0] m_bytes_reg, m_bytes_next;
    logic [3:0]  m_count_reg, m_count_next;
    logic        m_last_reg, m_last_next;

    logic [7:0]  width_eff;
    logic [4:0]  row_bytes;
    logic [3:0]  pages;
    logic [7:0]  pmask;
    logic [2:0]  p_inc;
    logic [10:0] page_base;
    logic        grp_last;
    logic        slot_free;
    logic        cfg_we;
    reg_idx_t    cfg_idx;

    fb_req_t    ram_req;
    logic [7:0] ram_rdata;
    oct_bytes_t cols;

    odpr_fb_ram u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    odpr_col_gather u_gather (
        .aclk     (aclk),
        .shift_en (rd_pend_reg),
        .din      (ram_rdata),
        .cols     (cols)
    );

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cols_reg <= 8'd96;
            page_count_reg <= 4'd2;
            col_offset_reg <= 8'd0;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_WIDTH:  width_cols_reg <= pwdata[7:0];
                REG_PAGES:  page_count_reg <= pwdata[3:0];
                REG_OFFSET: col_offset_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_WIDTH:  prdata = {24'd0, width_cols_reg};
            REG_PAGES:  prdata = {28'd0, page_count_reg};
            REG_OFFSET: prdata = {24'd0, col_offset_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // effective geometry
    always_comb begin
        if (width_cols_reg[7]) begin
            width_eff = 8'(MAX_WIDTH);
        end else if (width_cols_reg[6:3] == 4'd0) begin
            width_eff = 8'd8;
        end else begin
            width_eff = {width_cols_reg[7:3], 3'b000};
        end
        if (page_count_reg == 4'd0) begin
            pages = 4'd1;
        end else if (page_count_reg > 4'(MAX_PAGES)) begin
            pages = 4'(MAX_PAGES);
        end else begin
            pages = page_count_reg;
        end
    end

    assign row_bytes = width_eff[7:3];
    assign pmask     = 8'hFF >> (4'd8 - pages);
    assign p_inc     = (({1'b0, p_reg} + 4'd1) == pages) ? 3'd0 : p_reg + 3'd1;
    assign page_base = {8'd0, p_reg} * {3'd0, width_eff};
    assign grp_last  = ({1'b0, grp_cnt_reg} == (row_bytes - 5'd1));
    assign slot_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            dirty_reg     <= 8'd0;
            next_page_reg <= 3'd0;
            clr_cnt_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            row_cnt_reg   <= 4'd0;
            grp_cnt_reg   <= 4'd0;
        end else begin
            state_reg     <= state_next;
            dirty_reg     <= dirty_next;
            next_page_reg <= next_page_next;
            clr_cnt_reg   <= clr_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            m_valid_reg   <= m_valid_next;
            row_cnt_reg   <= row_cnt_next;
            grp_cnt_reg   <= grp_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg        <= p_next;
        row_addr_reg <= row_addr_next;
        grp_addr_reg <= grp_addr_next;
        carry_reg    <= carry_next;
        m_page_reg   <= m_page_next;
        m_bytes_reg  <= m_bytes_next;
        m_count_reg  <= m_count_next;
        m_last_reg   <= m_last_next;
    end

    always_comb begin
        state_next     = state_reg;
        dirty_next     = dirty_reg;
        next_page_next = next_page_reg;
        p_next         = p_reg;
        row_addr_next  = row_addr_reg;
        grp_addr_next  = grp_addr_reg;
        row_cnt_next   = row_cnt_reg;
        grp_cnt_next   = grp_cnt_reg;
        carry_next     = carry_reg;
        clr_cnt_next   = clr_cnt_reg;
        rd_pend_next   = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready;
        m_page_next    = m_page_reg;
        m_bytes_next   = m_bytes_reg;
        m_count_next   = m_count_reg;
        m_last_next    = m_last_reg;
        s_ready        = 1'b0;
        ram_req.we     = 1'b0;
        ram_req.waddr  = s_fb_address;
        ram_req.wdata  = s_fb_data;
        ram_req.re     = 1'b0;
        ram_req.raddr  = row_addr_reg;

        case (state_reg)
            ST_CLEAR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = clr_cnt_reg;
                ram_req.wdata = 8'd0;
                clr_cnt_next  = clr_cnt_reg + 10'd1;
                if (clr_cnt_reg == FB_LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (action_t'(s_action) == ACT_WRITE) begin
                        ram_req.we = 1'b1;
                        dirty_next = pmask;
                    end else if ((dirty_reg & pmask) != 8'd0) begin
                        p_next     = ({1'b0, next_page_reg} >= pages) ? 3'd0 : next_page_reg;
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (dirty_reg[p_reg]) begin
                    dirty_next[p_reg] = 1'b0;
                    next_page_next    = p_inc;
                    grp_addr_next     = page_base[FB_AW-1:0];
                    row_addr_next     = page_base[FB_AW-1:0];
                    row_cnt_next      = 4'd0;
                    grp_cnt_next      = 4'd0;
                    carry_next        = {DATA_CMD, COL_HI_CMD | {4'h0, col_offset_reg[7:4]},
                                         CTRL_CMD, COL_LO_CMD | {4'h0, col_offset_reg[3:0]},
                                         CTRL_CMD, PAGE_CMD | {5'd0, p_reg}, CTRL_CMD};
                    state_next        = ST_READ;
                end else begin
                    p_next = p_inc;
                end
            end
            ST_READ: begin
                if (row_cnt_reg < 4'd8) begin
                    ram_req.re    = 1'b1;
                    rd_pend_next  = 1'b1;
                    row_addr_next = row_addr_reg + {5'd0, row_bytes};
                    row_cnt_next  = row_cnt_reg + 4'd1;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    m_valid_next  = 1'b1;
                    m_page_next   = p_reg;
                    m_bytes_next  = {cols[0], carry_reg};
                    m_count_next  = 4'd8;
                    m_last_next   = 1'b0;
                    carry_next    = cols[7:1];
                    grp_cnt_next  = grp_cnt_reg + 4'd1;
                    grp_addr_next = grp_addr_reg + 10'd1;
                    row_addr_next = grp_addr_reg + 10'd1;
                    row_cnt_next  = 4'd0;
                    state_next    = grp_last ? ST_FINAL : ST_READ;
                end
            end
            ST_FINAL: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_page_next  = p_reg;
                    m_bytes_next = {8'd0, carry_reg};
                    m_count_next = 4'd7;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_page_number = m_page_reg;
    assign m_out_bytes   = m_bytes_reg;
    assign m_byte_count  = m_count_reg;
    assign m_last        = m_last_reg;

    a_last_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_byte_count == 4'd7)
        else $error("final word of a page does not hold seven bytes");

    a_row_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |-> row_cnt_reg <= 4'd8)
        else $error("row counter ran past eight rows");

    a_rd_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> $past(state_reg) == ST_READ)
        else $error("read data arrived outside a read phase");

    a_grp_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ || state_reg == ST_EMIT)
            |-> {1'b0, grp_cnt_reg} < row_bytes)
        else $error("column group counter beyond display width");

endmodule
